// ----- rtl/sfla_pkg.sv -----
// Package for the sorted free-list block allocator.
// Holds the shared FSM state type, result codes and the controller/datapath command
// and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfla_pkg;

  // Request opcode
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DUP   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_APOP,
    S_TRIM,
    S_TRIMRD,
    S_WALK,
    S_LINK,
    S_OUT
  } state_t;

  // Source of the granted block number
  typedef enum logic [1:0] {
    GR_ZERO,
    GR_HEAD,
    GR_COUNT
  } grant_t;

  // Link memory read address select
  typedef enum logic [1:0] {
    RD_NONE,
    RD_HEAD,
    RD_CUR
  } rd_op_t;

  // Link memory write select
  typedef enum logic [1:0] {
    WR_NONE,
    WR_B_HEAD,
    WR_PREV_B,
    WR_B_CUR
  } wr_op_t;

  // Free list head update
  typedef enum logic [1:0] {
    HD_KEEP,
    HD_B,
    HD_RD
  } head_op_t;

  // Walk predecessor update
  typedef enum logic [1:0] {
    PV_KEEP,
    PV_HEAD,
    PV_CUR
  } prev_op_t;

  // Extent counter update
  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_INC,
    CNT_DEC
  } count_op_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic      latch_in;
    logic      res_we;
    status_t   res_code;
    grant_t    grant;
    rd_op_t    rd_op;
    wr_op_t    wr_op;
    head_op_t  head_op;
    prev_op_t  prev_op;
    count_op_t count_op;
    logic      load_out;
  } sfla_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_alloc;
    logic head_valid;
    logic full;
    logic range_err;
    logic dup_head;
    logic is_top;
    logic above_head;
    logic trim_more;
    logic walk_more;
    logic walk_dup;
  } sfla_sts_t;

endpackage

`default_nettype wire

// ----- rtl/sfla_dpath.sv -----
// Datapath of the sorted free-list block allocator: extent counter, free list head,
// walk registers, link memory and result register. Depends on sfla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfla_dpath import sfla_pkg::*; #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire sfla_cmd_t   cmd,
  input  wire logic        in_op,
  input  wire logic [9:0]  in_block_id,
  output sfla_sts_t        sts,
  output logic      [1:0]  out_status,
  output logic      [9:0]  out_granted_block,
  output logic      [10:0] out_extent
);

  localparam int BW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int WW = (CW > 10) ? CW : 10;

  // Control state
  logic          head_valid_r, head_valid_nxt;
  logic [BW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Request and walk payload
  logic          op_r;
  logic [9:0]    bid_r;
  logic [BW-1:0] prev_r;
  logic [BW:0]   rd_data_r;

  // Result payload
  status_t       res_status_r;
  logic [BW-1:0] res_grant_r;
  status_t       out_status_r;
  logic [BW-1:0] out_grant_r;
  logic [CW-1:0] out_extent_r;

  logic [BW:0]   link_mem [MAX_BLOCKS];

  logic          rd_en;
  logic [BW-1:0] rd_addr;
  logic          wr_en;
  logic [BW-1:0] wr_addr;
  logic [BW:0]   wr_data;

  logic [BW-1:0] b;
  logic          cur_valid;
  logic [BW-1:0] cur;
  logic [CW-1:0] count_m1;

  assign b         = BW'(bid_r);
  assign cur_valid = rd_data_r[BW];
  assign cur       = rd_data_r[BW-1:0];
  assign count_m1  = count_r - CW'(1);

  // Decision flags for the controller
  always_comb begin
    sts.is_alloc   = (op_r == OP_ALLOC);
    sts.head_valid = head_valid_r;
    sts.full       = (count_r == CW'(MAX_BLOCKS));
    sts.range_err  = !(WW'(bid_r) < WW'(count_r));
    sts.dup_head   = head_valid_r && (b == head_r);
    sts.is_top     = (CW'(b) == count_m1);
    sts.above_head = b > head_r;
    sts.trim_more  = head_valid_r && (count_r != '0) && (CW'(head_r) == count_m1);
    sts.walk_more  = cur_valid && (cur > b);
    sts.walk_dup   = cur_valid && (cur == b);
  end

  // Select link memory addresses and write data
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_r;
    unique case (cmd.rd_op)
      RD_NONE: rd_en = 1'b0;
      RD_HEAD: begin
        rd_en   = 1'b1;
        rd_addr = head_r;
      end
      RD_CUR: begin
        rd_en   = 1'b1;
        rd_addr = cur;
      end
      default: rd_en = 1'b0;
    endcase
    wr_en   = 1'b0;
    wr_addr = b;
    wr_data = {head_valid_r, head_r};
    unique case (cmd.wr_op)
      WR_NONE: wr_en = 1'b0;
      WR_B_HEAD: begin
        wr_en   = 1'b1;
        wr_addr = b;
        wr_data = {head_valid_r, head_r};
      end
      WR_PREV_B: begin
        wr_en   = 1'b1;
        wr_addr = prev_r;
        wr_data = {1'b1, b};
      end
      WR_B_CUR: begin
        wr_en   = 1'b1;
        wr_addr = b;
        wr_data = rd_data_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Link memory with registered read; read data holds between reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= link_mem[rd_addr];
    end
  end

  // Next head and extent
  always_comb begin
    head_valid_nxt = head_valid_r;
    head_nxt       = head_r;
    unique case (cmd.head_op)
      HD_KEEP: head_nxt = head_r;
      HD_B: begin
        head_valid_nxt = 1'b1;
        head_nxt       = b;
      end
      HD_RD: begin
        head_valid_nxt = cur_valid;
        head_nxt       = cur;
      end
      default: head_nxt = head_r;
    endcase
    unique case (cmd.count_op)
      CNT_KEEP: count_nxt = count_r;
      CNT_INC:  count_nxt = count_r + CW'(1);
      CNT_DEC:  count_nxt = count_m1;
      default:  count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      head_r       <= '0;
      count_r      <= '0;
    end else begin
      head_valid_r <= head_valid_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
    end
  end

  // Capture request, walk predecessor and result payload
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r  <= in_op;
      bid_r <= in_block_id;
    end
    unique case (cmd.prev_op)
      PV_KEEP: prev_r <= prev_r;
      PV_HEAD: prev_r <= head_r;
      PV_CUR:  prev_r <= cur;
      default: prev_r <= prev_r;
    endcase
    if (cmd.res_we) begin
      res_status_r <= cmd.res_code;
      unique case (cmd.grant)
        GR_ZERO:  res_grant_r <= '0;
        GR_HEAD:  res_grant_r <= head_r;
        GR_COUNT: res_grant_r <= BW'(count_r);
        default:  res_grant_r <= '0;
      endcase
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_grant_r  <= res_grant_r;
      out_extent_r <= count_r;
    end
  end

  assign out_status        = out_status_r;
  assign out_granted_block = 10'(out_grant_r);
  assign out_extent        = 11'(out_extent_r);

endmodule

`default_nettype wire

// ----- rtl/sfla_ctrl.sv -----
// Controller of the sorted free-list block allocator: sequences allocate, trim, insert
// and walk steps and owns the request/result handshakes. Depends on sfla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfla_ctrl import sfla_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire sfla_sts_t sts,
  output sfla_cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        priority if (sts.is_alloc) begin
          state_nxt = sts.head_valid ? S_APOP : S_OUT;
        end else if (sts.range_err || sts.dup_head) begin
          state_nxt = S_OUT;
        end else if (sts.is_top) begin
          state_nxt = S_TRIM;
        end else if (!sts.head_valid || sts.above_head) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_APOP:   state_nxt = S_OUT;
      S_TRIM:   state_nxt = sts.trim_more ? S_TRIMRD : S_OUT;
      S_TRIMRD: state_nxt = S_TRIM;
      S_WALK: begin
        priority if (sts.walk_more) begin
          state_nxt = S_WALK;
        end else if (sts.walk_dup) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd          = '0;
    cmd.res_code = ST_OK;
    cmd.grant    = GR_ZERO;
    cmd.rd_op    = RD_NONE;
    cmd.wr_op    = WR_NONE;
    cmd.head_op  = HD_KEEP;
    cmd.prev_op  = PV_KEEP;
    cmd.count_op = CNT_KEEP;
    unique case (state_r)
      S_IDLE: cmd.latch_in = in_valid;
      S_EXEC: begin
        cmd.res_we = 1'b1;
        priority if (sts.is_alloc && sts.head_valid) begin
          cmd.grant = GR_HEAD;
          cmd.rd_op = RD_HEAD;
        end else if (sts.is_alloc && sts.full) begin
          cmd.res_code = ST_FULL;
        end else if (sts.is_alloc) begin
          cmd.grant    = GR_COUNT;
          cmd.count_op = CNT_INC;
        end else if (sts.range_err) begin
          cmd.res_code = ST_RANGE;
        end else if (sts.dup_head) begin
          cmd.res_code = ST_DUP;
        end else if (sts.is_top) begin
          cmd.count_op = CNT_DEC;
        end else if (!sts.head_valid || sts.above_head) begin
          cmd.wr_op   = WR_B_HEAD;
          cmd.head_op = HD_B;
        end else begin
          cmd.rd_op   = RD_HEAD;
          cmd.prev_op = PV_HEAD;
        end
      end
      S_APOP: cmd.head_op = HD_RD;
      S_TRIM: begin
        if (sts.trim_more) begin
          cmd.rd_op    = RD_HEAD;
          cmd.count_op = CNT_DEC;
        end
      end
      S_TRIMRD: cmd.head_op = HD_RD;
      S_WALK: begin
        priority if (sts.walk_more) begin
          cmd.rd_op   = RD_CUR;
          cmd.prev_op = PV_CUR;
        end else if (sts.walk_dup) begin
          cmd.res_we   = 1'b1;
          cmd.res_code = ST_DUP;
        end else begin
          cmd.wr_op = WR_PREV_B;
        end
      end
      S_LINK: cmd.wr_op    = WR_B_CUR;
      S_OUT:  cmd.load_out = out_free;
      default: cmd.latch_in = 1'b0;
    endcase
  end

  // Result valid: set on load, clear when taken
  always_comb begin
    out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sorted_free_list_block_allocator.sv -----
// Channel   Dir  Ports                                             Handshake
// request   in   in_op, in_block_id                                in_valid / in_stall
// result    out  out_status, out_granted_block, out_extent         out_valid / out_stall
//
// One request at a time; an allocate goes from execute to the result load, via a pop step
// when a free block is taken. A free goes straight to the load for errors and head inserts,
// via trim steps for a top free, or via a walk and link for a sorted insert (no link
// when the walk meets a duplicate). The next request is accepted in idle after the load,
// also while the result waits; a stalled result holds the next one in the final state.
// Reset (rst_n low, synchronous) empties the free list and the pool; no clearing pass.
// Top level; depends on sfla_pkg, sfla_ctrl and sfla_dpath.
`timescale 1ns / 1ps
`default_nettype none

module sorted_free_list_block_allocator import sfla_pkg::*; #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [9:0]  in_block_id,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [1:0]  out_status,
  output logic      [9:0]  out_granted_block,
  output logic      [10:0] out_extent
);

  sfla_cmd_t cmd;
  sfla_sts_t sts;

  sfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfla_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_op             (in_op),
    .in_block_id       (in_block_id),
    .sts               (sts),
    .out_status        (out_status),
    .out_granted_block (out_granted_block),
    .out_extent        (out_extent)
  );

  // The link memory never reads and writes in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_op != WR_NONE) |-> (cmd.rd_op == RD_NONE))
    else $error("link memory read and write in the same cycle");

  // An accepted request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted without going busy");

  // Error results never grant a block
  a_err_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_granted_block == '0))
    else $error("error result carries a granted block");

  // A new result loads only when the output register is free
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result overwrote a stalled result");

endmodule

`default_nettype wire
